/* src/bpa_pkg.sv */
`default_nettype none
package bpa_pkg;

  localparam int MAX_PAGES_DEF = 32768;
  localparam int TOP_RANK_DEF  = 16;
  localparam int LINK_W        = 16;
  localparam int RANK_W        = 5;
  localparam int ADDR_W        = 27;
  localparam int VALUE_W       = 16;
  localparam int FUNC_W        = 3;
  localparam int STATUS_W      = 2;
  localparam int PAGE_SHIFT    = 12;

  localparam logic [LINK_W-1:0] NO_BLOCK = 16'hFFFF;

  localparam logic [FUNC_W-1:0] FN_INIT  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_ALLOC = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FREE  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_QUERY = 3'd3;
  localparam logic [FUNC_W-1:0] FN_COUNT = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVAL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;

  // one write and one read port per store
  typedef struct packed {
    logic              link_we;
    logic [LINK_W-1:0] link_waddr;
    logic [LINK_W-1:0] link_wdata;
    logic [LINK_W-1:0] link_raddr;
    logic              mark_we;
    logic [LINK_W-1:0] mark_waddr;
    logic [RANK_W-1:0] mark_wdata;
    logic [LINK_W-1:0] mark_raddr;
  } mem_req_t;

  // pages in a block of rank r (r >= 1)
  function automatic logic [LINK_W-1:0] blk_pages(input logic [RANK_W-1:0] r);
    logic [RANK_W-1:0] sh;
    sh = r - RANK_W'(1);
    return LINK_W'(1) << sh;
  endfunction

endpackage
`default_nettype wire

/* src/bpa_store.sv */
`default_nettype none
module bpa_store import bpa_pkg::*; #(
  parameter int MAX_PAGES = MAX_PAGES_DEF
) (
  input  wire logic              clk_i,
  input  mem_req_t               req_i,
  output logic      [LINK_W-1:0] link_rdata_o,
  output logic      [RANK_W-1:0] mark_rdata_o
);

  localparam int PW = $clog2(MAX_PAGES);

  logic [LINK_W-1:0] link_mem [MAX_PAGES];
  logic [RANK_W-1:0] mark_mem [MAX_PAGES];

  always_ff @(posedge clk_i) begin
    if (req_i.link_we) begin
      link_mem[req_i.link_waddr[PW-1:0]] <= req_i.link_wdata;
    end
    link_rdata_o <= link_mem[req_i.link_raddr[PW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.mark_we) begin
      mark_mem[req_i.mark_waddr[PW-1:0]] <= req_i.mark_wdata;
    end
    mark_rdata_o <= mark_mem[req_i.mark_raddr[PW-1:0]];
  end

endmodule
`default_nettype wire

/* src/bpa_core.sv */
`default_nettype none
module bpa_core import bpa_pkg::*; #(
  parameter int MAX_PAGES = MAX_PAGES_DEF,
  parameter int TOP_RANK  = TOP_RANK_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [FUNC_W-1:0]   in_func_i,
  input  wire logic [RANK_W-1:0]   in_rank_i,
  input  wire logic [ADDR_W-1:0]   in_addr_i,
  input  wire logic [LINK_W-1:0]   region_size_i,
  output logic                     res_valid_o,
  input  wire logic                res_ready_i,
  output logic      [STATUS_W-1:0] res_status_o,
  output logic      [ADDR_W-1:0]   res_offs_o,
  output logic      [VALUE_W-1:0]  res_value_o,
  output mem_req_t                 mem_req_o,
  input  wire logic [LINK_W-1:0]   link_rdata_i,
  input  wire logic [RANK_W-1:0]   mark_rdata_i
);

  localparam int RW = (TOP_RANK > 1) ? $clog2(TOP_RANK) : 1;

  typedef enum logic [17:0] {
    S_CLEAR  = 18'h00001,
    S_IDLE   = 18'h00002,
    S_DISP   = 18'h00004,
    S_ASCAN  = 18'h00008,
    S_APOP   = 18'h00010,
    S_ASPLIT = 18'h00020,
    S_MARK   = 18'h00040,
    S_FCHK   = 18'h00080,
    S_FMERGE = 18'h00100,
    S_TWALK  = 18'h00200,
    S_TSTEP  = 18'h00400,
    S_QCHK   = 18'h00800,
    S_QLIST  = 18'h01000,
    S_QWALK  = 18'h02000,
    S_QSTEP  = 18'h04000,
    S_CLIST  = 18'h08000,
    S_CWALK  = 18'h10000,
    S_RESP   = 18'h20000
  } state_e;

  state_e            state_q, state_d;
  logic [FUNC_W-1:0] func_q, func_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [RANK_W-1:0] cur_q, cur_d;
  logic [LINK_W-1:0] blk_q, blk_d;
  logic [LINK_W-1:0] ptr_q, ptr_d;
  logic [LINK_W-1:0] prev_q, prev_d;
  logic [LINK_W-1:0] buddy_q, buddy_d;
  logic [LINK_W-1:0] cnt_q, cnt_d;
  logic [LINK_W-1:0] msz_q, msz_d;
  logic [RANK_W-1:0] mval_q, mval_d;
  logic [LINK_W-1:0] active_q, active_d;
  logic              rinit_q, rinit_d;
  logic [STATUS_W-1:0] st_q, st_d;
  logic [ADDR_W-1:0]   offs_q, offs_d;
  logic [VALUE_W-1:0]  val_q, val_d;
  logic [LINK_W-1:0]   head_q [TOP_RANK];

  logic              head_we, head_init;
  logic [LINK_W-1:0] head_wdata, head_rd;
  logic [RANK_W-1:0] hidx;
  logic [RW-1:0]     hi;
  logic [LINK_W-1:0] page16, sz_cur, n_sat, split_p, mark_p;
  logic [RANK_W-1:0] init_top;
  logic              page_in, rank_ok;
  mem_req_t          req;

  function automatic logic ok(input logic [LINK_W-1:0] x);
    return 32'(x) < MAX_PAGES;
  endfunction

  // largest rank whose block fits in n pages
  function automatic logic [RANK_W-1:0] top_of(input logic [LINK_W-1:0] n);
    logic [RANK_W-1:0] t;
    t = RANK_W'(1);
    for (int k = 1; k < TOP_RANK; k++) begin
      if ((32'd1 << k) <= 32'(n)) t = t + RANK_W'(1);
    end
    return t;
  endfunction

  assign page16   = LINK_W'(addr_q[ADDR_W-1:PAGE_SHIFT]);
  assign page_in  = page16 < active_q;
  assign rank_ok  = (rank_q != '0) && (rank_q <= RANK_W'(TOP_RANK));
  assign hidx     = (state_q == S_ASPLIT) ? cur_q - RANK_W'(1) : cur_q;
  assign hi       = RW'(hidx - RANK_W'(1));
  assign head_rd  = head_q[hi];
  assign sz_cur   = blk_pages(cur_q);
  assign n_sat    = (32'(region_size_i) > MAX_PAGES) ? LINK_W'(MAX_PAGES) : region_size_i;
  assign init_top = top_of(n_sat);
  assign split_p  = blk_q + blk_pages(cur_q - RANK_W'(1));
  assign mark_p   = blk_q + cnt_q;

  always_comb begin
    state_d = state_q;  func_d = func_q;   rank_d = rank_q;  addr_d = addr_q;
    cur_d = cur_q;      blk_d = blk_q;     ptr_d = ptr_q;    prev_d = prev_q;
    buddy_d = buddy_q;  cnt_d = cnt_q;     msz_d = msz_q;    mval_d = mval_q;
    active_d = active_q; rinit_d = rinit_q;
    st_d = st_q;        offs_d = offs_q;   val_d = val_q;
    head_we = 1'b0;     head_init = 1'b0;  head_wdata = '0;
    req = '0;
    req.link_raddr = ptr_q;
    req.mark_raddr = page16;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        req.mark_we    = 1'b1;
        req.mark_waddr = cnt_q;
        cnt_d = cnt_q + LINK_W'(1);
        if (cnt_q == LINK_W'(MAX_PAGES - 1)) begin
          cnt_d   = '0;
          state_d = rinit_q ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          func_d  = in_func_i;
          rank_d  = in_rank_i;
          addr_d  = in_addr_i;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        st_d = ST_INVAL; offs_d = '0; val_d = '0;
        cur_d = rank_q;
        state_d = S_RESP;
        unique case (func_q)
          FN_INIT: begin
            if (region_size_i != '0) begin
              active_d       = n_sat;
              head_init      = 1'b1;
              req.link_we    = 1'b1;
              req.link_waddr = '0;
              req.link_wdata = NO_BLOCK;
              cnt_d   = '0;
              rinit_d = 1'b1;
              st_d    = ST_OK;
              state_d = S_CLEAR;
            end
          end
          FN_ALLOC: if (rank_ok) state_d = S_ASCAN;
          FN_FREE:  if (page_in) state_d = S_FCHK;
          FN_QUERY: if (page_in) state_d = S_QCHK;
          FN_COUNT: if (rank_ok) state_d = S_CLIST;
          default: ;
        endcase
      end
      S_ASCAN: begin
        if (cur_q > RANK_W'(TOP_RANK)) begin
          st_d = ST_NOSPACE;
          state_d = S_RESP;
        end else if (ok(head_rd)) begin
          blk_d = head_rd;
          req.link_raddr = head_rd;
          state_d = S_APOP;
        end else begin
          cur_d = cur_q + RANK_W'(1);
        end
      end
      S_APOP: begin
        head_we = 1'b1; head_wdata = link_rdata_i;
        state_d = S_ASPLIT;
      end
      S_ASPLIT: begin
        if (cur_q > rank_q) begin
          if (ok(split_p)) begin
            req.link_we = 1'b1; req.link_waddr = split_p; req.link_wdata = head_rd;
            head_we = 1'b1; head_wdata = split_p;
          end
          cur_d = cur_q - RANK_W'(1);
        end else begin
          msz_d = blk_pages(rank_q); mval_d = rank_q; cnt_d = '0;
          state_d = S_MARK;
        end
      end
      S_MARK: begin
        if (ok(mark_p)) begin
          req.mark_we = 1'b1; req.mark_waddr = mark_p; req.mark_wdata = mval_q;
        end
        cnt_d = cnt_q + LINK_W'(1);
        if (cnt_q == msz_q - LINK_W'(1)) begin
          if (func_q == FN_ALLOC) begin
            st_d    = ST_OK;
            offs_d  = {blk_q[ADDR_W-PAGE_SHIFT-1:0], PAGE_SHIFT'(0)};
            state_d = S_RESP;
          end else begin
            state_d = S_FMERGE;
          end
        end
      end
      S_FCHK: begin
        if (mark_rdata_i != '0 && mark_rdata_i <= RANK_W'(TOP_RANK) &&
            addr_q[PAGE_SHIFT-1:0] == '0 &&
            (page16 & (blk_pages(mark_rdata_i) - LINK_W'(1))) == '0) begin
          blk_d = page16; cur_d = mark_rdata_i;
          msz_d = blk_pages(mark_rdata_i); mval_d = '0; cnt_d = '0;
          state_d = S_MARK;
        end else begin
          state_d = S_RESP;
        end
      end
      S_FMERGE: begin
        if (cur_q < RANK_W'(TOP_RANK)) begin
          buddy_d = blk_q ^ sz_cur;
          ptr_d   = head_rd;
          prev_d  = NO_BLOCK;
          state_d = S_TWALK;
        end else begin
          req.link_we = 1'b1; req.link_waddr = blk_q; req.link_wdata = head_rd;
          head_we = 1'b1; head_wdata = blk_q;
          st_d = ST_OK; state_d = S_RESP;
        end
      end
      S_TWALK: begin
        if (!ok(ptr_q)) begin
          // buddy not free: park the merged block here
          req.link_we = 1'b1; req.link_waddr = blk_q; req.link_wdata = head_rd;
          head_we = 1'b1; head_wdata = blk_q;
          st_d = ST_OK; state_d = S_RESP;
        end else begin
          state_d = S_TSTEP;
        end
      end
      S_TSTEP: begin
        if (ptr_q == buddy_q) begin
          if (prev_q == NO_BLOCK) begin
            head_we = 1'b1; head_wdata = link_rdata_i;
          end else begin
            req.link_we = 1'b1; req.link_waddr = prev_q; req.link_wdata = link_rdata_i;
          end
          if (buddy_q < blk_q) blk_d = buddy_q;
          cur_d   = cur_q + RANK_W'(1);
          state_d = S_FMERGE;
        end else begin
          prev_d = ptr_q; ptr_d = link_rdata_i;
          state_d = S_TWALK;
        end
      end
      S_QCHK: begin
        if (mark_rdata_i != '0) begin
          val_d = VALUE_W'(mark_rdata_i); st_d = ST_OK; state_d = S_RESP;
        end else begin
          cur_d = RANK_W'(TOP_RANK); state_d = S_QLIST;
        end
      end
      S_QLIST: begin
        ptr_d = head_rd; state_d = S_QWALK;
      end
      S_QWALK: begin
        if (!ok(ptr_q)) begin
          if (cur_q == RANK_W'(1)) begin
            state_d = S_RESP;
          end else begin
            cur_d = cur_q - RANK_W'(1); state_d = S_QLIST;
          end
        end else if (page16 >= ptr_q &&
                     {1'b0, page16} < ({1'b0, ptr_q} + {1'b0, sz_cur})) begin
          val_d = VALUE_W'(cur_q); st_d = ST_OK; state_d = S_RESP;
        end else begin
          state_d = S_QSTEP;
        end
      end
      S_QSTEP: begin
        ptr_d = link_rdata_i; state_d = S_QWALK;
      end
      S_CLIST: begin
        ptr_d = head_rd; cnt_d = '0; state_d = S_CWALK;
      end
      S_CWALK: begin
        if (ok(ptr_q) && 32'(cnt_q) < MAX_PAGES) begin
          cnt_d = cnt_q + LINK_W'(1); state_d = S_QSTEP;
        end else begin
          val_d = cnt_q; st_d = ST_OK; state_d = S_RESP;
        end
      end
      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // count walk reuses the query step state; return to the count loop
    if (state_q == S_QSTEP && func_q == FN_COUNT) state_d = S_CWALK;
  end

  assign mem_req_o    = req;
  assign res_status_o = st_q;
  assign res_offs_o   = offs_q;
  assign res_value_o  = val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cnt_q    <= '0;
      active_q <= '0;
      rinit_q  <= 1'b0;
      for (int k = 0; k < TOP_RANK; k++) head_q[k] <= NO_BLOCK;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      active_q <= active_d;
      rinit_q  <= rinit_d;
      if (head_init) begin
        for (int k = 0; k < TOP_RANK; k++) begin
          head_q[k] <= (k == int'(init_top) - 1) ? '0 : NO_BLOCK;
        end
      end else if (head_we) begin
        head_q[hi] <= head_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;   rank_q <= rank_d;   addr_q <= addr_d;
    cur_q <= cur_d;     blk_q <= blk_d;     ptr_q <= ptr_d;
    prev_q <= prev_d;   buddy_q <= buddy_d; msz_q <= msz_d;
    mval_q <= mval_d;   st_q <= st_d;       offs_q <= offs_d;
    val_q <= val_d;
  end

endmodule
`default_nettype wire

/* src/buddy_page_allocator.sv */
// Channel   Dir  Handshake                    Payload (low bit up)
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: func[2:0]; tdata: rank[4:0],
//                                             address_offset[31:5]
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: status[1:0], block_offset[28:2],
//                                             value[44:29], zeros above
// cfg       in   cfg_we_i                     cfg_wdata_i: region size in pages
//
// One item at a time; s_axis_tready is high only while the sequencer is idle.
// Alloc scans the rank lists upward, pops a block, splits it down to the rank asked
// for, then writes its rank mark to each page; free clears the marks of the block, then
// merges level by level; query reads the mark, else walks the rank lists; count walks one.
// Reset and init sweep the rank marks one page a cycle, no item
// taken meanwhile; a result waits in an output register while the next item is taken.
`default_nettype none
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int MAX_PAGES = MAX_PAGES_DEF,
  parameter int TOP_RANK  = TOP_RANK_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // rank[4:0], address_offset[31:5]
  input  wire logic [2:0]  s_axis_tuser,   // func[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // status[1:0], block_offset[28:2], value[44:29]
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i     // region size in pages
);

  logic [LINK_W-1:0]   region_size_q;
  logic                res_valid, res_ready;
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_offs;
  logic [VALUE_W-1:0]  res_value;
  mem_req_t            mem_req;
  logic [LINK_W-1:0]   link_rdata;
  logic [RANK_W-1:0]   mark_rdata;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [ADDR_W-1:0]   out_offs_q;
  logic [VALUE_W-1:0]  out_value_q;

  // region size, read only by init
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_size_q <= 16'd1024;
    end else if (cfg_we_i) begin
      region_size_q <= cfg_wdata_i;
    end
  end

  bpa_core #(
    .MAX_PAGES(MAX_PAGES),
    .TOP_RANK (TOP_RANK)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_func_i    (s_axis_tuser),
    .in_rank_i    (s_axis_tdata[4:0]),
    .in_addr_i    (s_axis_tdata[31:5]),
    .region_size_i(region_size_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_status_o (res_status),
    .res_offs_o   (res_offs),
    .res_value_o  (res_value),
    .mem_req_o    (mem_req),
    .link_rdata_i (link_rdata),
    .mark_rdata_i (mark_rdata)
  );

  bpa_store #(
    .MAX_PAGES(MAX_PAGES)
  ) u_store (
    .clk_i       (clk_i),
    .req_i       (mem_req),
    .link_rdata_o(link_rdata),
    .mark_rdata_o(mark_rdata)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_status_q <= res_status;
      out_offs_q   <= res_offs;
      out_value_q  <= res_value;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_value_q, out_offs_q, out_status_q};

endmodule
`default_nettype wire

/* src/bpa_checker.sv */
`default_nettype none
module bpa_checker import bpa_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);

  // one item in flight: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] <= ST_NOSPACE)
    else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[44:2] == '0)
    else $error("failed item carries data");

  a_page_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[13:2] == '0)
    else $error("block offset not page aligned");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire
